// ===== rtl/mbcnr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcnr_pkg: shared types and constants of the MIDI bend and note remapper
// Holds the bend settings bundle, the 14-bit bend anchors and the MIDI codes.
// ----------------------------------------------------------------------------
package mbcnr_pkg;

  localparam int unsigned BendW = 14;

  // Bend anchors: rest position, full scale and the two output scale factors
  localparam logic [BendW-1:0] BEND_CENTER = 14'd8192;
  localparam logic [BendW-1:0] BEND_MAX    = 14'd16383;
  localparam logic [BendW-1:0] BEND_MIN    = 14'd0;
  localparam logic [BendW-1:0] SCALE_UP    = 14'd8191;
  localparam logic [BendW-1:0] SCALE_DOWN  = 14'd8192;

  // Curve codes: linear, power 1..5, inverted power 6..10
  localparam logic [3:0] CURVE_LINEAR  = 4'd0;
  localparam logic [3:0] CURVE_POW_MAX = 4'd5;
  localparam logic [3:0] CURVE_MAX     = 4'd10;

  // MIDI message kinds (upper nibble of the status byte)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [7:0] CC_BREATH    = 8'd2;
  localparam logic [7:0] BREATH_RESET = 8'd100;
  localparam logic [6:0] NOTE_MAX     = 7'h7F;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER    = 3'd0;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd1;
  localparam logic [2:0] REG_UP_SPAN   = 3'd2;
  localparam logic [2:0] REG_DOWN_SPAN = 3'd3;
  localparam logic [2:0] REG_CURVE     = 3'd4;
  localparam logic [2:0] REG_VEL_FLOOR = 3'd5;
  localparam logic [2:0] REG_TRANSPOSE = 3'd6;
  localparam logic [2:0] REG_CHAN_MODE = 3'd7;

  typedef struct packed {
    logic [BendW-1:0] center;
    logic [BendW-1:0] dead_zone;
    logic [BendW-1:0] up_span;
    logic [BendW-1:0] down_span;
    logic [7:0]       curve;
  } bend_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/mbcnr_bend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbcnr_bend: pitch bend curve engine
// Restoring divider, then one shared multiplier for the power steps and the
// final scaling, all under one small sequencer.
// ----------------------------------------------------------------------------
module mbcnr_bend
  import mbcnr_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [BendW-1:0] vin_i,
  input  wire bend_cfg_t        cfg_i,
  input  wire logic             ack_i,
  output logic                  done_o,
  output logic      [BendW-1:0] value_o
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned YW  = F + 1;
  localparam int unsigned MBW = (F > BendW) ? F : BendW;
  localparam int unsigned PW  = YW + MBW;
  localparam int unsigned CW  = $clog2(F + 1);
  localparam logic [YW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SHAPE, S_POW, S_POWW, S_SCALE, S_FIN, S_DONE
  } state_e;

  state_e           state_q;
  logic             up_q, inv_q;
  logic [3:0]       code_q;
  logic [BendW-1:0] span_q, rem_q;
  logic [F-1:0]     quo_q, base_q;
  logic [YW-1:0]    y_q;
  logic [CW-1:0]    cnt_q;
  logic [2:0]       steps_q;
  logic [PW-1:0]    prod_q;
  logic [BendW-1:0] value_q;

  // Setup decode from the incoming bend word
  logic signed [BendW:0] diff;
  logic [BendW-1:0]      absd, excess, span_sel;
  logic                  dead, up;
  logic [3:0]            code_raw, code_sel;

  always_comb begin
    diff     = $signed({1'b0, vin_i}) - $signed({1'b0, cfg_i.center});
    absd     = diff[BendW] ? BendW'(-diff) : diff[BendW-1:0];
    dead     = absd <= cfg_i.dead_zone;
    up       = !diff[BendW];
    excess   = absd - cfg_i.dead_zone;
    span_sel = up ? cfg_i.up_span : cfg_i.down_span;
    code_raw = up ? cfg_i.curve[3:0] : cfg_i.curve[7:4];
    code_sel = (code_raw > CURVE_MAX) ? CURVE_MAX : code_raw;
  end

  // Divider step
  logic [BendW:0]   rem_sh;
  logic             rem_ge;
  logic [BendW-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, 1'b0};
    rem_ge = rem_sh >= {1'b0, span_q};
    rem_nx = rem_ge ? BendW'(rem_sh - {1'b0, span_q}) : rem_sh[BendW-1:0];
  end

  // Curve setup from the quotient
  logic          shp_inv;
  logic [3:0]    shp_k;
  logic [F-1:0]  shp_base;

  always_comb begin
    shp_inv  = code_q > CURVE_POW_MAX;
    shp_k    = shp_inv ? (code_q - CURVE_POW_MAX) : code_q;
    shp_base = shp_inv ? F'(ONE - {1'b0, quo_q}) : quo_q;
  end

  // Shared multiplier and rounding
  logic [MBW-1:0] mul_b;
  logic [PW-1:0]  prod_d, rnd;
  logic [YW-1:0]  y_rnd;
  logic [BendW-1:0] s_rnd;

  always_comb begin
    if (state_q == S_SCALE) begin
      mul_b = up_q ? MBW'(SCALE_UP) : MBW'(SCALE_DOWN);
    end else begin
      mul_b = MBW'(base_q);
    end
    prod_d = PW'(y_q) * PW'(mul_b);
    rnd    = prod_q + HALF;
    y_rnd  = YW'(rnd >> F);
    s_rnd  = BendW'(rnd >> F);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      up_q    <= 1'b0;
      inv_q   <= 1'b0;
      code_q  <= '0;
      span_q  <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      base_q  <= '0;
      y_q     <= '0;
      cnt_q   <= '0;
      steps_q <= '0;
      prod_q  <= '0;
      value_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            up_q   <= up;
            code_q <= code_sel;
            span_q <= span_sel;
            rem_q  <= excess;
            quo_q  <= '0;
            cnt_q  <= CW'(F);
            inv_q  <= 1'b0;
            steps_q <= '0;
            if (dead) begin
              value_q <= BEND_CENTER;
              state_q <= S_DONE;
            end else if (span_sel == '0) begin
              value_q <= up ? BEND_MAX : BEND_MIN;
              state_q <= S_DONE;
            end else if (excess >= span_sel) begin
              // Saturated fraction: every curve gives full scale
              y_q     <= ONE;
              state_q <= S_SCALE;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[F-2:0], rem_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          priority if (quo_q == '0) begin
            y_q <= '0;
          end else if (code_q == CURVE_LINEAR) begin
            y_q <= {1'b0, quo_q};
          end else begin
            base_q  <= shp_base;
            y_q     <= {1'b0, shp_base};
            steps_q <= 3'(shp_k - 4'd1);
            inv_q   <= shp_inv;
          end
          state_q <= S_POW;
        end
        S_POW: begin
          if (steps_q == '0) begin
            if (inv_q) begin
              y_q <= ONE - y_q;
            end
            state_q <= S_SCALE;
          end else begin
            prod_q  <= prod_d;
            state_q <= S_POWW;
          end
        end
        S_POWW: begin
          y_q     <= y_rnd;
          steps_q <= steps_q - 1'b1;
          state_q <= S_POW;
        end
        S_SCALE: begin
          prod_q  <= prod_d;
          state_q <= S_FIN;
        end
        S_FIN: begin
          value_q <= up_q ? BendW'(BEND_CENTER + s_rnd) : BendW'(BEND_CENTER - s_rnd);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = state_q == S_DONE;
  assign value_o = value_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("bend start while engine busy");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < span_q)
    else $error("divider remainder not below span");

  a_y_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE |-> y_q <= ONE)
    else $error("curve output above full scale");
`endif

endmodule
`default_nettype wire

// ===== rtl/midi_bend_curve_note_remapper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_bend_curve_note_remapper_unit: MIDI pitch bend shaper and note remapper
// Timing: an accepted word is held, then moves into the output register once its
//   result is ready and the output has room; a pitch bend outside the dead zone
//   with a nonzero span first waits for the bend engine to finish.
// Throughput: one word at a time; the bit-serial divider (one quotient bit per
//   cycle) and the shared multiplier (a multiply state and a write-back state per
//   power step) set the bend time.
// Reset: settings return to their defaults, breath level to 100, both channels empty.
// ----------------------------------------------------------------------------
module midi_bend_curve_note_remapper_unit
  import mbcnr_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input message channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  status_byte_i,
  input  wire logic [7:0]  first_data_i,
  input  wire logic [7:0]  second_data_i,
  input  wire logic [1:0]  byte_count_i,
  // output message channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_status_o,
  output logic [7:0]       out_first_o,
  output logic [7:0]       out_second_o,
  output logic [1:0]       out_count_o,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [13:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BendW-1:0] center_q, dead_zone_q, up_span_q, down_span_q;
  logic [7:0]       curve_q;
  logic [6:0]       vel_floor_q;
  logic [7:0]       transpose_q;
  logic [5:0]       chan_mode_q;

  // Always take configuration words; the user must write them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= BEND_CENTER;
      dead_zone_q <= 14'd700;
      up_span_q   <= 14'd4000;
      down_span_q <= 14'd4000;
      curve_q     <= '0;
      vel_floor_q <= '0;
      transpose_q <= '0;
      chan_mode_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CENTER:    center_q    <= cfg_data_i;
        REG_DEAD_ZONE: dead_zone_q <= cfg_data_i;
        REG_UP_SPAN:   up_span_q   <= cfg_data_i;
        REG_DOWN_SPAN: down_span_q <= cfg_data_i;
        REG_CURVE:     curve_q     <= cfg_data_i[7:0];
        REG_VEL_FLOOR: vel_floor_q <= cfg_data_i[6:0];
        REG_TRANSPOSE: transpose_q <= cfg_data_i[7:0];
        REG_CHAN_MODE: chan_mode_q <= cfg_data_i[5:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Channel filter: a setting above 16 acts as 16, zero passes all channels
  // --------------------------------------------------------------------------
  logic [4:0] filt;
  assign filt = (chan_mode_q[4:0] > 5'd16) ? 5'd16 : chan_mode_q[4:0];

  function automatic logic chan_pass(input logic [4:0] f, input logic [3:0] chan);
    chan_pass = (f == 5'd0) || ({1'b0, chan} + 5'd1 == f);
  endfunction

  // --------------------------------------------------------------------------
  // Accept side: hold the word, start the bend engine, capture breath
  // --------------------------------------------------------------------------
  logic       in_acc;
  logic       busy_q, need_bend_q;
  logic [7:0] st_q, d1_q, d2_q;
  logic [1:0] cnt_q;
  logic [7:0] breath_q;
  logic       acc_pass, acc_bend, acc_breath;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;

  always_comb begin
    acc_pass   = (byte_count_i == 2'd3) && chan_pass(filt, status_byte_i[3:0]);
    acc_bend   = acc_pass && (status_byte_i[7:4] == KIND_BEND);
    acc_breath = acc_pass && (status_byte_i[7:4] == KIND_CTRL) && (first_data_i == CC_BREATH);
  end

  // Bend word: all eight bits of the first byte, ORed with the second byte
  // shifted up by seven; clamp to 14 bits.
  logic [BendW:0]   vin_raw;
  logic [BendW-1:0] vin;
  always_comb begin
    vin_raw = {second_data_i, 7'd0} | {7'd0, first_data_i};
    vin     = (vin_raw > {1'b0, BEND_MAX}) ? BEND_MAX : vin_raw[BendW-1:0];
  end

  bend_cfg_t  bend_cfg;
  logic       bend_done, load;
  logic [BendW-1:0] bend_val;

  assign bend_cfg = '{center:    center_q,
                      dead_zone: dead_zone_q,
                      up_span:   up_span_q,
                      down_span: down_span_q,
                      curve:     curve_q};

  mbcnr_bend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_bend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && acc_bend),
    .vin_i   (vin),
    .cfg_i   (bend_cfg),
    .ack_i   (load),
    .done_o  (bend_done),
    .value_o (bend_val)
  );

  // --------------------------------------------------------------------------
  // Result assembly from the held word
  // --------------------------------------------------------------------------
  logic              res_ready;
  logic [7:0]        o0, o1, o2;
  logic signed [9:0] note_sum;
  logic [6:0]        note;
  logic [7:0]        vel_breath;

  always_comb begin
    note_sum = $signed({2'b00, d1_q}) + $signed({{2{transpose_q[7]}}, transpose_q});
    priority if (note_sum[9]) begin
      note = 7'd0;
    end else if (note_sum > $signed({3'b000, NOTE_MAX})) begin
      note = NOTE_MAX;
    end else begin
      note = note_sum[6:0];
    end
    vel_breath = (breath_q < {1'b0, vel_floor_q}) ? {1'b0, vel_floor_q} : breath_q;

    o0 = st_q;
    o1 = d1_q;
    o2 = d2_q;
    if (cnt_q != 2'd3) begin
      // Short message: pass, zero the bytes beyond the count
      if (cnt_q == 2'd0) o0 = '0;
      if (cnt_q < 2'd2) o1 = '0;
      o2 = '0;
    end else if (chan_pass(filt, st_q[3:0])) begin
      unique case (st_q[7:4])
        KIND_BEND: begin
          o1 = {1'b0, bend_val[6:0]};
          o2 = {1'b0, bend_val[13:7]};
        end
        KIND_NOTE_ON: begin
          o1 = {1'b0, note};
          if (chan_mode_q[5] && (d2_q == 8'd0)) begin
            // Velocity zero turns into note off on the same channel
            o0 = {KIND_NOTE_OFF, st_q[3:0]};
            o2 = '0;
          end else if (vel_floor_q != '0) begin
            o2 = vel_breath;
          end
        end
        KIND_NOTE_OFF: o1 = {1'b0, note};
        default: ;
      endcase
    end
  end

  // Move the result into the output register when it is done and there is room.
  assign res_ready = !need_bend_q || bend_done;
  assign load      = busy_q && res_ready && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      need_bend_q  <= 1'b0;
      breath_q     <= BREATH_RESET;
      st_q         <= '0;
      d1_q         <= '0;
      d2_q         <= '0;
      cnt_q        <= '0;
      out_valid_o  <= 1'b0;
      out_status_o <= '0;
      out_first_o  <= '0;
      out_second_o <= '0;
      out_count_o  <= '0;
    end else begin
      if (in_acc) begin
        busy_q      <= 1'b1;
        need_bend_q <= acc_bend;
        st_q        <= status_byte_i;
        d1_q        <= first_data_i;
        d2_q        <= second_data_i;
        cnt_q       <= byte_count_i;
        if (acc_breath) begin
          breath_q <= second_data_i;
        end
      end else if (load) begin
        busy_q <= 1'b0;
      end

      if (load) begin
        out_valid_o  <= 1'b1;
        out_status_o <= o0;
        out_first_o  <= o1;
        out_second_o <= o2;
        out_count_o  <= cnt_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !bend_done)
    else $error("bend engine done with no word held");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q))
    else $error("output word appeared with no word held");

  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && in_stall_o)
    else $error("accepted word not held");
`endif

endmodule
`default_nettype wire
